@@ hdl/mt19937_random_generator_defines.svh @@
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Shared property templates for the generator's assertions.
// ----------------------------------------------------------------------------
`ifndef MT19937_RANDOM_GENERATOR_DEFINES_SVH
`define MT19937_RANDOM_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MTRG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MTRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mtrg_pkg.sv @@
// ----------------------------------------------------------------------------
// MT19937 generator package
// Constants, operation codes and shared types.
// ----------------------------------------------------------------------------
package mtrg_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned MT_N   = 624;
   localparam int unsigned MT_M   = 397;
   localparam int unsigned IDX_W  = 10;

   localparam logic [WORD_W-1:0] INIT_MUL   = 32'h6c07_8965;
   localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
   localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

   localparam int unsigned INIT_SHIFT = 30;
   localparam int unsigned TEMPER_U   = 11;
   localparam int unsigned TEMPER_S   = 7;
   localparam int unsigned TEMPER_T   = 15;
   localparam int unsigned TEMPER_L   = 18;

   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 40;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [1:0] {
      OP_RESEED = 2'd0,
      OP_RAW    = 2'd1,
      OP_RANGE  = 2'd2,
      OP_BOOL   = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [WORD_W-1:0] range_low;
      logic [WORD_W-1:0] span;
      logic              span_zero;
      logic [WORD_W-1:0] threshold;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic seeded;
   } stat_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_TWIST,
      ST_TEMPER,
      ST_DIV_START,
      ST_DIVIDE,
      ST_RESULT
   } core_state_type;

endpackage

@@ hdl/mtrg_front.sv @@
// ----------------------------------------------------------------------------
// MT19937 generator front end
// Takes request items, decodes op and span, queues commands for the core.
// ----------------------------------------------------------------------------
module mtrg_front #(
   parameter int unsigned DEPTH = mtrg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mtrg_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [mtrg_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output mtrg_pkg::cmd_type                   cmd
);
   import mtrg_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            entry;
   logic               push;
   logic               pop;

   // decode and classify the incoming item
   always_comb begin
      entry.op        = op_type'(req_tuser);
      entry.range_low = req_tdata[WORD_W-1:0];
      entry.threshold = req_tdata[3*WORD_W-1:2*WORD_W];
      entry.span      = req_tdata[2*WORD_W-1:WORD_W] - req_tdata[WORD_W-1:0];
      entry.span_zero = (entry.span == '0);
   end

   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

@@ hdl/mtrg_divider.sv @@
// ----------------------------------------------------------------------------
// MT19937 generator remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module mtrg_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mtrg_pkg::div_req_type div_req,
   output mtrg_pkg::div_rsp_type div_rsp
);
   import mtrg_pkg::*;

   localparam int unsigned STEPS = WORD_W;
   localparam int unsigned CNT_W = $clog2(STEPS);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   dvd_ff;
   logic [WORD_W-1:0]   dvs_ff;
   logic [WORD_W:0]     trial;
   logic                trial_ge;

   always_comb begin
      trial    = {rem_ff, dvd_ff[WORD_W-1]};
      trial_ge = (trial >= {1'b0, dvs_ff});
      rem_in   = trial_ge ? WORD_W'(trial - {1'b0, dvs_ff}) : trial[WORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[WORD_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ hdl/mtrg_core.sv @@
// ----------------------------------------------------------------------------
// MT19937 generator core
// State store, seeding pass, per-word twist, tempering and result register.
// ----------------------------------------------------------------------------
module mtrg_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mtrg_pkg::WORD_W-1:0]   seed,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  mtrg_pkg::cmd_type             cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mtrg_pkg::WORD_W-1:0]   rsp_value,
   output logic                          rsp_bool,
   output logic                          rsp_error,
   output mtrg_pkg::stat_type            stat
);
   import mtrg_pkg::*;

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] y;
      y = w ^ (w >> TEMPER_U);
      y = y ^ ((y << TEMPER_S) & TEMPER_B);
      y = y ^ ((y << TEMPER_T) & TEMPER_C);
      y = y ^ (y >> TEMPER_L);
      return y;
   endfunction

   core_state_type      state_ff, state_in;
   logic                seeded_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    cnt_ff;
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic                rsp_bool_ff;
   logic                rsp_error_ff;

   cmd_type             cmd_ff;
   logic [WORD_W-1:0]   prev_ff;
   logic [WORD_W-1:0]   a_ff;
   logic [WORD_W-1:0]   b_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [WORD_W-1:0]   res_value_ff;
   logic                res_bool_ff;
   logic                res_error_ff;

   logic [WORD_W-1:0]   store_mem [MT_N];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   logic [IDX_W-1:0]    idx_p1;
   logic [IDX_W-1:0]    idx_pm;
   logic [WORD_W-1:0]   seed_mix;
   logic [WORD_W-1:0]   seed_word;
   logic [WORD_W-1:0]   twist_y;
   logic [WORD_W-1:0]   twist_word;
   logic [WORD_W-1:0]   tempered;
   logic                seed_last;
   logic                take_cmd;
   logic                out_load;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // ---- address and datapath helpers ----
   always_comb begin
      idx_p1 = (idx_ff == IDX_W'(MT_N - 1)) ? '0 : idx_ff + 1'b1;
      idx_pm = (idx_ff >= IDX_W'(MT_N - MT_M)) ? idx_ff - IDX_W'(MT_N - MT_M)
                                              : idx_ff + IDX_W'(MT_M);
      seed_mix  = prev_ff ^ (prev_ff >> INIT_SHIFT);
      seed_word = (cnt_ff == '0) ? seed
                                 : WORD_W'(seed_mix * INIT_MUL) + WORD_W'(cnt_ff);
      twist_y    = (a_ff & UPPER_MASK) | (b_ff & LOWER_MASK);
      twist_word = rd_data_ff ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : '0);
      tempered   = temper(word_ff);
      seed_last  = (cnt_ff == IDX_W'(MT_N - 1));
      take_cmd   = (state_ff == ST_IDLE) && cmd_valid;
      out_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd.op == OP_RESEED || !seeded_ff) ? ST_SEED : ST_RD_A;
            end
         end
         ST_SEED: begin
            if (seed_last) begin
               state_in = (cmd_ff.op == OP_RESEED) ? ST_RESULT : ST_RD_A;
            end
         end
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_RD_C;
         ST_RD_C:  state_in = ST_TWIST;
         ST_TWIST: state_in = ST_TEMPER;
         ST_TEMPER: begin
            state_in = (cmd_ff.op == OP_RANGE && !cmd_ff.span_zero) ? ST_DIV_START
                                                                     : ST_RESULT;
         end
         ST_DIV_START: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- state outputs ----
   always_comb begin
      cmd_ready        = 1'b0;
      mem_we           = 1'b0;
      mem_waddr        = idx_ff;
      mem_wdata        = twist_word;
      mem_raddr        = idx_ff;
      div_req.start    = 1'b0;
      div_req.dividend = word_ff;
      div_req.divisor  = cmd_ff.span;
      unique case (state_ff)
         ST_IDLE: cmd_ready = 1'b1;
         ST_SEED: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = seed_word;
         end
         ST_RD_A:      mem_raddr = idx_ff;
         ST_RD_B:      mem_raddr = idx_p1;
         ST_RD_C:      mem_raddr = idx_pm;
         ST_TWIST:     mem_we = 1'b1;
         ST_DIV_START: div_req.start = 1'b1;
         default: ;
      endcase
   end

   // ---- state store ----
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (take_cmd) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_SEED) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (state_ff == ST_SEED && seed_last) begin
            seeded_ff <= 1'b1;
            idx_ff    <= '0;
         end else if (state_ff == ST_TEMPER) begin
            idx_ff <= idx_p1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      if (take_cmd) begin
         cmd_ff <= cmd;
      end
      if (state_ff == ST_SEED) begin
         prev_ff <= seed_word;
      end
      if (state_ff == ST_RD_B) begin
         a_ff <= rd_data_ff;
      end
      if (state_ff == ST_RD_C) begin
         b_ff <= rd_data_ff;
      end
      if (state_ff == ST_TWIST) begin
         word_ff <= twist_word;
      end
      if (state_ff == ST_SEED && seed_last) begin
         res_value_ff <= '0;
         res_bool_ff  <= 1'b0;
         res_error_ff <= 1'b0;
      end else if (state_ff == ST_TEMPER) begin
         res_value_ff <= '0;
         res_bool_ff  <= 1'b0;
         res_error_ff <= 1'b0;
         case (cmd_ff.op)
            OP_RAW: res_value_ff <= tempered;
            OP_RANGE: begin
               if (cmd_ff.span_zero) begin
                  res_value_ff <= cmd_ff.range_low;
                  res_error_ff <= 1'b1;
               end
            end
            OP_BOOL: res_bool_ff <= (tempered <= cmd_ff.threshold);
            default: ;
         endcase
      end else if (state_ff == ST_DIVIDE && div_rsp.done) begin
         res_value_ff <= div_rsp.remainder + cmd_ff.range_low;
      end
      if (state_ff == ST_TEMPER) begin
         word_ff <= tempered;
      end
      if (out_load) begin
         rsp_value_ff <= res_value_ff;
         rsp_bool_ff  <= res_bool_ff;
         rsp_error_ff <= res_error_ff;
      end
   end

   mtrg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_bool    = rsp_bool_ff;
   assign rsp_error   = rsp_error_ff;
   assign stat.busy   = (state_ff != ST_IDLE);
   assign stat.seeded = seeded_ff;

endmodule

@@ hdl/mt19937_random_generator.sv @@
// ----------------------------------------------------------------------------
// MT19937 random generator
// Raw and boolean items: read, twist and temper states, then rsp_tvalid; the
// core takes one item at a time. Ranged items add the 32-step remainder unit.
// Reseed items run the seeding pass, writing one store word a cycle.
// First word item after reset seeds automatically.
// Reset clears queue, sequencer, index and seeded flag; store is not cleared.
// ----------------------------------------------------------------------------
`include "mt19937_random_generator_defines.svh"

module mt19937_random_generator #(
   parameter int unsigned QUEUE_DEPTH = mtrg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration: seed register
   input  logic                              csr_wr_en,
   input  logic [mtrg_pkg::WORD_W-1:0]       csr_wr_data,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] range_low, [63:32] range_high, [95:64] bool_threshold
   input  logic [mtrg_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] op
   input  logic [mtrg_pkg::REQ_USER_W-1:0]   req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] value, [32] bool_result, [39:33] zero
   output logic [mtrg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] range_error
   output logic                              rsp_tuser
);
   import mtrg_pkg::*;

   // Seed register; only sampled by the core's seeding pass.
   logic [WORD_W-1:0]  seed_ff;

   // Front-to-core command handoff.
   logic               cmd_valid;
   logic               cmd_ready;
   cmd_type            cmd;

   // Core result register outputs.
   logic [WORD_W-1:0]  rsp_value;
   logic               rsp_bool;
   logic               rsp_error;
   stat_type           stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // Front: takes items, decodes op, precomputes the range span and its
   // zero flag, and buffers commands so the request side keeps moving while
   // the core is busy with a long seeding pass or a division.
   mtrg_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // Core: 624-word store with one read and one write port. Each word is
   // twisted on demand (three reads, one write), tempered, then shaped into
   // the raw, ranged or boolean result and held in an output register.
   mtrg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_value),
      .rsp_bool  (rsp_bool),
      .rsp_error (rsp_error),
      .stat      (stat)
   );

   assign rsp_tdata = {{(RSP_DATA_W - WORD_W - 1){1'b0}}, rsp_bool, rsp_value};
   assign rsp_tuser = rsp_error;

   // ---- assertions ----
   // A command handed to the core always starts work.
   `MTRG_ASSERT_NEXT(a_handoff_busy, clock, reset, cmd_valid && cmd_ready, stat.busy, "core idle after command handoff")
   // A result only appears as the end of core work.
   `MTRG_ASSERT_IMPLY(a_rsp_from_core, clock, reset, $rose(rsp_tvalid), $past(stat.busy), "result without core work")
   // Range error and boolean outcome never mix in one item.
   `MTRG_ASSERT_IMPLY(a_err_excl, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[WORD_W], "range error with boolean set")
   // Nothing is presented right after reset.
   `MTRG_ASSERT_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_tvalid, "result valid after reset")

endmodule

@@ tb/sv/mt19937_random_generator_tb.sv @@
// ----------------------------------------------------------------------------
// MT19937 random generator testbench
// Drives reseed, raw, ranged and boolean requests into the generator. A
// self-contained twister model predicts each response, and every response is
// checked field by field in order. Seed register writes happen only while the
// block is idle. Both channels idle at random, with one long response stall.
// ----------------------------------------------------------------------------
module mt19937_random_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtrg_pkg::*;

   localparam int unsigned LONG_STALL_CYCLES = 1500;
   localparam int unsigned WATCHDOG_LIMIT    = 20000;
   localparam int unsigned END_SETTLE_CYCLES = 60;

   typedef logic [WORD_W-1:0] word_type;

   // one request item as the sender sees it
   typedef struct {
      op_type   op;
      word_type low;
      word_type high;
      word_type thresh;
   } draw_request_type;

   // one response item
   typedef struct {
      word_type value;
      logic     bool_result;
      logic     range_error;
   } draw_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_wr_en   = 1'b0;
   logic [WORD_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // [31:0] range_low, [63:32] range_high, [95:64] bool_threshold
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   // [1:0] op
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // [31:0] value, [32] bool_result, [39:33] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] range_error
   logic                  rsp_tuser;

   // items waiting to be offered, expectations waiting for their response
   draw_request_type draw_requests[$];
   draw_result_type  expected_draws[$];
   draw_request_type offered_req;

   // twister model state
   word_type    twist_words[MT_N];
   int unsigned twist_pos;
   bit          twist_seeded;
   word_type    seed_reg;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_requests;
   int unsigned stalls_served;
   int unsigned stall_left;
   int unsigned quiet_cycles;
   int unsigned errors;

   always #5 clock = ~clock;

   mt19937_random_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // ---------------------------------------------------------------------
   // Twister model
   // ---------------------------------------------------------------------

   // Fill the store from the seed register, restart at word 0.
   function automatic void seed_twister();
      twist_words[0] = seed_reg;
      for (int unsigned k = 1; k < MT_N; k++) begin
         twist_words[k] = word_type'(INIT_MUL *
            (twist_words[k-1] ^ (twist_words[k-1] >> INIT_SHIFT)) + k);
      end
      twist_pos    = 0;
      twist_seeded = 1'b1;
   endfunction

   // Regenerate all 624 words in place.
   function automatic void regen_twister();
      word_type mix;
      word_type nxt;
      for (int unsigned k = 0; k < MT_N; k++) begin
         mix = (twist_words[k] & UPPER_MASK) |
               (twist_words[(k + 1) % MT_N] & LOWER_MASK);
         nxt = twist_words[(k + MT_M) % MT_N] ^ (mix >> 1);
         if (mix[0]) begin
            nxt = nxt ^ MATRIX_A;
         end
         twist_words[k] = nxt;
      end
   endfunction

   // Next tempered word; seeds on first use and regenerates at index 0.
   function automatic word_type next_tempered();
      word_type y;
      if (!twist_seeded) begin
         seed_twister();
      end
      if (twist_pos >= MT_N) begin
         twist_pos = 0;
      end
      if (twist_pos == 0) begin
         regen_twister();
      end
      y = twist_words[twist_pos];
      y = y ^ (y >> TEMPER_U);
      y = y ^ ((y << TEMPER_S) & TEMPER_B);
      y = y ^ ((y << TEMPER_T) & TEMPER_C);
      y = y ^ (y >> TEMPER_L);
      twist_pos = (twist_pos + 1) % MT_N;
      return y;
   endfunction

   // Expected response for one accepted request; advances the model.
   function automatic draw_result_type predict_draw(draw_request_type r);
      draw_result_type o;
      word_type        w;
      word_type        span;
      o.value       = '0;
      o.bool_result = 1'b0;
      o.range_error = 1'b0;
      case (r.op)
         OP_RESEED: begin
            seed_twister();
         end
         OP_RAW: begin
            o.value = next_tempered();
         end
         OP_RANGE: begin
            w    = next_tempered();
            span = r.high - r.low;
            if (span == '0) begin
               // empty span: flag it and hand back the low bound
               o.value       = r.low;
               o.range_error = 1'b1;
            end else begin
               o.value = (w % span) + r.low;
            end
         end
         default: begin
            w             = next_tempered();
            o.bool_result = (w <= r.thresh);
         end
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------

   function automatic draw_request_type make_req(op_type op, word_type low,
                                                 word_type high, word_type thresh);
      draw_request_type r;
      r.op     = op;
      r.low    = low;
      r.high   = high;
      r.thresh = thresh;
      return r;
   endfunction

   // Random request; unused fields carry random noise.
   function automatic draw_request_type random_req(bit allow_reseed);
      draw_request_type r;
      int unsigned      pick;
      int unsigned      shape;
      r    = make_req(OP_RAW, $urandom, $urandom, $urandom);
      pick = $urandom_range(99);
      if (allow_reseed && pick < 4) begin
         r.op = OP_RESEED;
      end else if (pick < 36) begin
         r.op = OP_RAW;
      end else if (pick < 70) begin
         r.op  = OP_RANGE;
         shape = $urandom_range(9);
         if (shape == 0) begin
            r.high = r.low;                              // empty span
         end else if (shape <= 3) begin
            r.high = r.low + $urandom_range(16, 1);      // narrow span
         end else if (shape == 4) begin
            r.high = r.low - $urandom_range(16, 1);      // span near 2^32
         end
      end else begin
         r.op  = OP_BOOL;
         shape = $urandom_range(9);
         if (shape == 0) begin
            r.thresh = '0;
         end else if (shape == 1) begin
            r.thresh = '1;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sequencing helpers (called from the stimulus process)
   // ---------------------------------------------------------------------

   // Hold off until every queued item went out and every response came back.
   task automatic wait_drained();
      while (draw_requests.size() != 0 || req_tvalid || expected_draws.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Seed register write, only while the block is idle.
   task automatic write_seed(word_type v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      seed_reg = v;
      @(negedge clock);
   endtask

   task automatic queue_random(int unsigned count, bit allow_reseed);
      for (int unsigned i = 0; i < count; i++) begin
         draw_requests.push_back(random_req(allow_reseed));
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: offers the head of draw_requests, holds it until taken.
   // Prediction happens at the accepting edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expected_draws.push_back(predict_draw(offered_req));
         end
         if (draw_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered_req = draw_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {offered_req.thresh, offered_req.high, offered_req.low};
            req_tuser  <= offered_req.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: checks each response against the oldest expectation
   // and drives rsp_tready, including the long stall when one is requested.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      draw_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_draws.size() == 0) begin
               $error("response with nothing expected: value=%h", rsp_tdata[WORD_W-1:0]);
               errors++;
            end else begin
               want = expected_draws.pop_front();
               if (rsp_tdata[WORD_W-1:0] !== want.value) begin
                  $error("value: expected %h, got %h", want.value, rsp_tdata[WORD_W-1:0]);
                  errors++;
               end
               if (rsp_tdata[WORD_W] !== want.bool_result) begin
                  $error("bool_result: expected %b, got %b", want.bool_result,
                         rsp_tdata[WORD_W]);
                  errors++;
               end
               if (rsp_tuser !== want.range_error) begin
                  $error("range_error: expected %b, got %b", want.range_error, rsp_tuser);
                  errors++;
               end
            end
         end
         if (stall_left == 0 && stalls_served != stall_requests) begin
            stalls_served++;
            stall_left = LONG_STALL_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: too long with no item moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      errors         = 0;
      stall_requests = 0;
      stalls_served  = 0;
      send_idle_pct  = 29;
      recv_idle_pct  = 82;
      seed_reg       = SEED_RESET;
      twist_pos      = 0;
      twist_seeded   = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: first word request seeds from the reset seed value.
      draw_requests.push_back(make_req(OP_RAW, '0, '0, '0));
      draw_requests.push_back(make_req(OP_RAW, '1, '1, '1));
      draw_requests.push_back(make_req(OP_RANGE, 32'h0, 32'hffff_ffff, '0));
      draw_requests.push_back(make_req(OP_RANGE, 32'd5, 32'd5, '0));       // empty span
      draw_requests.push_back(make_req(OP_RANGE, 32'h0, 32'h0, '1));       // empty at zero
      draw_requests.push_back(make_req(OP_RANGE, '1, '1, '0));             // empty at max
      draw_requests.push_back(make_req(OP_RANGE, '1, 32'h0, '0));          // wrap, span one
      draw_requests.push_back(make_req(OP_RANGE, 32'hffff_fff0, 32'h10, '0)); // wrap
      draw_requests.push_back(make_req(OP_RANGE, 32'd100, 32'd101, '0));   // span one
      draw_requests.push_back(make_req(OP_RANGE, 32'd1, 32'd0, '0));       // span 2^32-1
      draw_requests.push_back(make_req(OP_RANGE, 32'h8000_0000, 32'h7fff_ffff, '1));
      draw_requests.push_back(make_req(OP_BOOL, '0, '0, 32'h0));
      draw_requests.push_back(make_req(OP_BOOL, '1, '1, 32'hffff_ffff));
      draw_requests.push_back(make_req(OP_BOOL, '0, '0, 32'h7fff_ffff));
      draw_requests.push_back(make_req(OP_BOOL, '0, '0, 32'h8000_0000));
      draw_requests.push_back(make_req(OP_RESEED, '1, '1, '1));
      draw_requests.push_back(make_req(OP_RAW, '0, '0, '0));
      draw_requests.push_back(make_req(OP_RESEED, '0, '0, '0));
      draw_requests.push_back(make_req(OP_BOOL, '0, '0, 32'h0000_0001));
      draw_requests.push_back(make_req(OP_RANGE, 32'd7, 32'd10, '0));
      wait_drained();

      // Phase A, random: all-ones seed
      write_seed('1);
      draw_requests.push_back(make_req(OP_RESEED, '0, '0, '0));
      queue_random(80, 1'b1);
      wait_drained();

      // Phase B: roles swapped, zero seed then a random seed
      send_idle_pct = 82;
      recv_idle_pct = 29;
      write_seed('0);
      draw_requests.push_back(make_req(OP_RESEED, '0, '0, '0));
      queue_random(80, 1'b1);
      wait_drained();
      write_seed($urandom);
      draw_requests.push_back(make_req(OP_RESEED, '0, '0, '0));
      queue_random(40, 1'b1);
      wait_drained();

      // Phase C: no idling, no random reseeds, long enough to wrap the 624-word store.
      // A long response stall early on backs the request side up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_seed($urandom);
      draw_requests.push_back(make_req(OP_RESEED, '0, '0, '0));
      queue_random(60, 1'b0);
      stall_requests++;
      queue_random(590, 1'b0);
      wait_drained();

      repeat (END_SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
